// File: src/bpq_pkg.sv
package bpq_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int TIMER_WIDTH = 16;
  localparam int INDEX_WIDTH = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int DATA_WIDTH = (TIMER_WIDTH > NUM_BUTTONS) ? TIMER_WIDTH : NUM_BUTTONS;
  localparam int REG_INDEX_WIDTH = 3;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [NUM_BUTTONS-1:0] button_mask_t;

  localparam button_mask_t ENABLED_MASK_RESET = '1;
  localparam button_mask_t REPEAT_MASK_RESET = NUM_BUTTONS'(48);
  localparam timer_t EDGE_DEBOUNCE_RESET = TIMER_WIDTH'(50);
  localparam timer_t SETTLE_RESET = TIMER_WIDTH'(20);
  localparam timer_t LONG_PRESS_RESET = TIMER_WIDTH'(600);
  localparam timer_t REPEAT_TICKS_RESET = TIMER_WIDTH'(150);

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_ENABLED_MASK        = 3'd0,
    REG_REPEAT_MASK         = 3'd1,
    REG_EDGE_DEBOUNCE_TICKS = 3'd2,
    REG_SETTLE_TICKS        = 3'd3,
    REG_LONG_PRESS_TICKS    = 3'd4,
    REG_REPEAT_TICKS        = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_LONG    = 2'd1,
    EV_REPEAT  = 2'd2,
    EV_RELEASE = 2'd3
  } event_kind_t;

  typedef struct packed {
    timer_t edge_debounce_ticks;
    timer_t settle_ticks;
    timer_t long_press_ticks;
    timer_t repeat_ticks;
  } lane_cfg_t;

  typedef struct packed {
    logic        hit;
    event_kind_t kind;
  } lane_evt_t;

endpackage

// File: src/bpq_lane.sv
module bpq_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                level,
  input  logic                enabled,
  input  logic                repeat_on,
  input  bpq_pkg::lane_cfg_t  cfg,
  output bpq_pkg::lane_evt_t  evt
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SETTLE = 4'b0010,
    PH_LONG   = 4'b0100,
    PH_REPEAT = 4'b1000
  } phase_t;

  function automatic bpq_pkg::timer_t sat_inc(input bpq_pkg::timer_t v);
    return (&v) ? v : v + bpq_pkg::timer_t'(1);
  endfunction

  function automatic logic reached(input bpq_pkg::timer_t t, input bpq_pkg::timer_t lim);
    return (&t) || (t >= lim);
  endfunction

  phase_t                  phase;
  phase_t                  phase_next;
  bpq_pkg::timer_t         phase_timer;
  bpq_pkg::timer_t         phase_timer_next;
  bpq_pkg::timer_t         since_edge;
  bpq_pkg::timer_t         since_edge_next;
  logic                    previous_level;
  logic                    fell;
  logic                    hit;
  bpq_pkg::event_kind_t    kind;

  assign fell = previous_level && !level;

  always_comb begin
    since_edge_next = sat_inc(since_edge);
    phase_next = phase;
    phase_timer_next = phase_timer;
    hit = 1'b0;
    kind = bpq_pkg::EV_PRESS;
    if (!enabled) begin
      phase_next = PH_IDLE;
      phase_timer_next = '0;
    end else begin
      if (phase != PH_IDLE) begin
        phase_timer_next = sat_inc(phase_timer);
      end else if (fell && reached(since_edge_next, cfg.edge_debounce_ticks)) begin
        since_edge_next = '0;
        phase_next = PH_SETTLE;
        phase_timer_next = '0;
      end
      case (phase_next)
        PH_SETTLE: begin
          if (reached(phase_timer_next, cfg.settle_ticks)) begin
            phase_timer_next = '0;
            if (!level) begin
              hit = 1'b1;
              kind = bpq_pkg::EV_PRESS;
              phase_next = repeat_on ? PH_LONG : PH_IDLE;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_LONG: begin
          if (level) begin
            phase_next = PH_IDLE;
            phase_timer_next = '0;
          end else if (reached(phase_timer_next, cfg.long_press_ticks)) begin
            hit = 1'b1;
            kind = bpq_pkg::EV_LONG;
            phase_next = PH_REPEAT;
            phase_timer_next = '0;
          end
        end
        PH_REPEAT: begin
          if (reached(phase_timer_next, cfg.repeat_ticks)) begin
            phase_timer_next = '0;
            hit = 1'b1;
            if (level) begin
              kind = bpq_pkg::EV_RELEASE;
              phase_next = PH_IDLE;
            end else begin
              kind = bpq_pkg::EV_REPEAT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      phase_timer <= '0;
      since_edge <= '1;
      previous_level <= 1'b1;
    end else if (step) begin
      phase <= phase_next;
      phase_timer <= phase_timer_next;
      since_edge <= since_edge_next;
      previous_level <= level;
    end
  end

  assign evt.hit = hit;
  assign evt.kind = kind;

endmodule

// File: src/bpq_drain.sv
module bpq_drain (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           tick_valid,
  input  bpq_pkg::lane_evt_t [bpq_pkg::NUM_BUTTONS-1:0]  evts,
  output logic                                           tick_take,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [bpq_pkg::INDEX_WIDTH-1:0]                button_index,
  output logic [1:0]                                     event_kind,
  output logic                                           last_of_tick
);

  bpq_pkg::button_mask_t                               pend_mask;
  bpq_pkg::button_mask_t                               pend_mask_next;
  bpq_pkg::event_kind_t [bpq_pkg::NUM_BUTTONS-1:0]     pend_kind;
  bpq_pkg::button_mask_t                               new_mask;
  bpq_pkg::button_mask_t                               rest;
  logic [bpq_pkg::INDEX_WIDTH-1:0]                     sel;
  logic                                                out_free;
  logic                                                pop;
  logic                                                can_load;

  always_comb begin
    for (int i = 0; i < bpq_pkg::NUM_BUTTONS; i++) begin
      new_mask[i] = evts[i].hit;
    end
  end

  always_comb begin
    sel = '0;
    for (int i = bpq_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
      if (pend_mask[i]) begin
        sel = bpq_pkg::INDEX_WIDTH'(i);
      end
    end
  end

  assign rest = pend_mask & ~(bpq_pkg::button_mask_t'(1) << sel);
  assign out_free = !out_valid || out_ready;
  assign pop = out_free && (|pend_mask);
  assign can_load = (pend_mask == '0) || (pop && (rest == '0));
  assign tick_take = tick_valid && can_load;

  always_comb begin
    pend_mask_next = pend_mask;
    if (tick_take) begin
      pend_mask_next = new_mask;
    end else if (pop) begin
      pend_mask_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      pend_mask <= pend_mask_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      for (int i = 0; i < bpq_pkg::NUM_BUTTONS; i++) begin
        pend_kind[i] <= evts[i].kind;
      end
    end
    if (pop) begin
      button_index <= sel;
      event_kind <= pend_kind[sel];
      last_of_tick <= (rest == '0);
    end
  end

endmodule

// File: src/button_press_qualifier.sv
// Qualifies eight active-low buttons once per tick: debounced press, then for
// buttons in the repeat mask a long press, auto repeats and a release. Each
// accepted tick beat is registered, then evaluated by one qualifier lane per
// button once the drain can load it; its events drain one per cycle while
// out_ready allows from a pending-event register into the output register in
// increasing button order, with last_of_tick set on the final one. A tick
// with events holds off the next until its last event reaches the single
// output event port; a quiet tick stream is taken every cycle. Events pass the
// tick, pending-event and output registers. Configuration writes take effect at once.
module button_press_qualifier (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    write_enable,
  input  logic [bpq_pkg::REG_INDEX_WIDTH-1:0]     reg_index,
  input  logic [bpq_pkg::DATA_WIDTH-1:0]          write_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [bpq_pkg::NUM_BUTTONS-1:0]         button_levels,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [bpq_pkg::INDEX_WIDTH-1:0]         button_index,
  output logic [1:0]                              event_kind,
  output logic                                    last_of_tick
);

  bpq_pkg::button_mask_t                               enabled_mask;
  bpq_pkg::button_mask_t                               repeat_mask;
  bpq_pkg::lane_cfg_t                                  lane_cfg;
  bpq_pkg::button_mask_t                               in_levels;
  logic                                                in_full;
  logic                                                tick_take;
  bpq_pkg::lane_evt_t [bpq_pkg::NUM_BUTTONS-1:0]       evts;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask <= bpq_pkg::ENABLED_MASK_RESET;
      repeat_mask <= bpq_pkg::REPEAT_MASK_RESET;
      lane_cfg.edge_debounce_ticks <= bpq_pkg::EDGE_DEBOUNCE_RESET;
      lane_cfg.settle_ticks <= bpq_pkg::SETTLE_RESET;
      lane_cfg.long_press_ticks <= bpq_pkg::LONG_PRESS_RESET;
      lane_cfg.repeat_ticks <= bpq_pkg::REPEAT_TICKS_RESET;
    end else if (write_enable) begin
      case (reg_index)
        bpq_pkg::REG_ENABLED_MASK:
          enabled_mask <= write_data[bpq_pkg::NUM_BUTTONS-1:0];
        bpq_pkg::REG_REPEAT_MASK:
          repeat_mask <= write_data[bpq_pkg::NUM_BUTTONS-1:0];
        bpq_pkg::REG_EDGE_DEBOUNCE_TICKS:
          lane_cfg.edge_debounce_ticks <= write_data[bpq_pkg::TIMER_WIDTH-1:0];
        bpq_pkg::REG_SETTLE_TICKS:
          lane_cfg.settle_ticks <= write_data[bpq_pkg::TIMER_WIDTH-1:0];
        bpq_pkg::REG_LONG_PRESS_TICKS:
          lane_cfg.long_press_ticks <= write_data[bpq_pkg::TIMER_WIDTH-1:0];
        bpq_pkg::REG_REPEAT_TICKS:
          lane_cfg.repeat_ticks <= write_data[bpq_pkg::TIMER_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !in_full || tick_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (tick_take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_levels <= button_levels;
    end
  end

  for (genvar g = 0; g < bpq_pkg::NUM_BUTTONS; g++) begin : g_lane
    bpq_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .step      (tick_take),
      .level     (in_levels[g]),
      .enabled   (enabled_mask[g]),
      .repeat_on (repeat_mask[g]),
      .cfg       (lane_cfg),
      .evt       (evts[g])
    );
  end

  bpq_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (in_full),
    .evts         (evts),
    .tick_take    (tick_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_index (button_index),
    .event_kind   (event_kind),
    .last_of_tick (last_of_tick)
  );

`ifndef SYNTH
  a_take_needs_tick: assert property (@(posedge clk) disable iff (rst)
    tick_take |-> in_full)
    else $error("tick evaluated with no registered tick beat");

  a_tick_held: assert property (@(posedge clk) disable iff (rst)
    (in_full && !tick_take) |=> in_full)
    else $error("registered tick beat lost before evaluation");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("event beat presented right after reset");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_LONG_WAIT,
    ST_REPEATING
  } qual_state_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] index;
    event_kind_t            kind;
    logic                   last;
  } button_event_t;

  localparam button_mask_t RESET_CFG_TICKS [5] = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF};
  localparam button_mask_t FAST_CFG_TICKS [14] = '{
    8'hFF, 8'h00, 8'h00, 8'h00, 8'h0F, 8'hFF, 8'h00,
    8'h00, 8'hF0, 8'hF0, 8'h0F, 8'h00, 8'h3C, 8'hFF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [REG_INDEX_WIDTH-1:0] reg_index = '0;
  logic [DATA_WIDTH-1:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  button_mask_t button_levels = '1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_WIDTH-1:0] button_index;
  logic [1:0] event_kind;
  logic last_of_tick;

  button_mask_t cfg_enabled = ENABLED_MASK_RESET;
  button_mask_t cfg_repeat = REPEAT_MASK_RESET;
  timer_t cfg_debounce = EDGE_DEBOUNCE_RESET;
  timer_t cfg_settle = SETTLE_RESET;
  timer_t cfg_long_press = LONG_PRESS_RESET;
  timer_t cfg_repeat_ticks = REPEAT_TICKS_RESET;

  qual_state_t lane_state [NUM_BUTTONS];
  timer_t lane_timer [NUM_BUTTONS];
  timer_t lane_since_edge [NUM_BUTTONS];
  logic lane_prev_level [NUM_BUTTONS];

  button_mask_t pending_ticks [$];
  button_event_t expected_events [$];

  button_mask_t held_levels = '1;
  int unsigned hold_left [NUM_BUTTONS];

  int unsigned send_gap = 0;
  bit send_idling = 1'b1;
  int unsigned recv_stall = 0;
  bit recv_idling = 1'b1;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned cycle_count = 0;
  bit failed = 1'b0;

  button_press_qualifier DUT (
    .clk           (clk),
    .rst           (rst),
    .write_enable  (write_enable),
    .reg_index     (reg_index),
    .write_data    (write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_levels (button_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .button_index  (button_index),
    .event_kind    (event_kind),
    .last_of_tick  (last_of_tick)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic timer_t sat_inc(timer_t value);
    return (value == '1) ? value : value + 1'b1;
  endfunction

  function automatic logic reached(timer_t count, timer_t limit);
    return (count == '1) || (count >= limit);
  endfunction

  task automatic qualify_tick(input button_mask_t levels);
    button_event_t tick_events [NUM_BUTTONS];
    int count;
    logic fell;
    logic has_event;
    event_kind_t kind;
    count = 0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      fell = lane_prev_level[i] && !levels[i];
      lane_since_edge[i] = sat_inc(lane_since_edge[i]);
      lane_prev_level[i] = levels[i];
      has_event = 1'b0;
      kind = EV_PRESS;
      if (!cfg_enabled[i]) begin
        lane_state[i] = ST_IDLE;
        lane_timer[i] = '0;
      end else begin
        if (lane_state[i] != ST_IDLE) begin
          lane_timer[i] = sat_inc(lane_timer[i]);
        end else if (fell && reached(lane_since_edge[i], cfg_debounce)) begin
          lane_since_edge[i] = '0;
          lane_state[i] = ST_SETTLE;
          lane_timer[i] = '0;
        end
        case (lane_state[i])
          ST_SETTLE: begin
            if (reached(lane_timer[i], cfg_settle)) begin
              lane_timer[i] = '0;
              if (!levels[i]) begin
                has_event = 1'b1;
                kind = EV_PRESS;
                lane_state[i] = cfg_repeat[i] ? ST_LONG_WAIT : ST_IDLE;
              end else begin
                lane_state[i] = ST_IDLE;
              end
            end
          end
          ST_LONG_WAIT: begin
            if (levels[i]) begin
              lane_state[i] = ST_IDLE;
              lane_timer[i] = '0;
            end else if (reached(lane_timer[i], cfg_long_press)) begin
              has_event = 1'b1;
              kind = EV_LONG;
              lane_state[i] = ST_REPEATING;
              lane_timer[i] = '0;
            end
          end
          ST_REPEATING: begin
            if (reached(lane_timer[i], cfg_repeat_ticks)) begin
              lane_timer[i] = '0;
              has_event = 1'b1;
              if (levels[i]) begin
                kind = EV_RELEASE;
                lane_state[i] = ST_IDLE;
              end else begin
                kind = EV_REPEAT;
              end
            end
          end
          default: begin
          end
        endcase
        if (has_event) begin
          tick_events[count].index = INDEX_WIDTH'(i);
          tick_events[count].kind = kind;
          tick_events[count].last = 1'b0;
          count++;
        end
      end
    end
    for (int k = 0; k < count; k++) begin
      tick_events[k].last = (k == count - 1);
      expected_events.push_back(tick_events[k]);
    end
  endtask

  function automatic button_mask_t next_levels();
    if ($urandom_range(0, 9) == 0) begin
      return button_mask_t'($urandom);
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (hold_left[i] == 0) begin
        held_levels[i] = !held_levels[i];
        hold_left[i] = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 14);
      end
      hold_left[i]--;
    end
    return held_levels;
  endfunction

  function automatic timer_t pick_ticks(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0: return timer_t'(lo);
      1: return '1;
      default: return timer_t'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic write_reg(reg_index_t idx, logic [DATA_WIDTH-1:0] value);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value;
    case (idx)
      REG_ENABLED_MASK: cfg_enabled = value[NUM_BUTTONS-1:0];
      REG_REPEAT_MASK: cfg_repeat = value[NUM_BUTTONS-1:0];
      REG_EDGE_DEBOUNCE_TICKS: cfg_debounce = value[TIMER_WIDTH-1:0];
      REG_SETTLE_TICKS: cfg_settle = value[TIMER_WIDTH-1:0];
      REG_LONG_PRESS_TICKS: cfg_long_press = value[TIMER_WIDTH-1:0];
      REG_REPEAT_TICKS: cfg_repeat_ticks = value[TIMER_WIDTH-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic program_config(button_mask_t enabled, button_mask_t repeating,
                                timer_t debounce, timer_t settle,
                                timer_t long_press, timer_t rpt);
    write_reg(REG_ENABLED_MASK, DATA_WIDTH'(enabled));
    write_reg(REG_REPEAT_MASK, DATA_WIDTH'(repeating));
    write_reg(REG_EDGE_DEBOUNCE_TICKS, DATA_WIDTH'(debounce));
    write_reg(REG_SETTLE_TICKS, DATA_WIDTH'(settle));
    write_reg(REG_LONG_PRESS_TICKS, DATA_WIDTH'(long_press));
    write_reg(REG_REPEAT_TICKS, DATA_WIDTH'(rpt));
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic drain_all();
    do begin
      @(negedge clk);
    end while (pending_ticks.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        qualify_tick(button_levels);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          in_valid <= 1'b1;
          button_levels <= pending_ticks.pop_front();
          if ($urandom_range(0, 29) == 0) send_idling = !send_idling;
          send_gap = send_idling ? $urandom_range(0, 17) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    button_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got button %0d event %0d last %0b",
                   $time, button_index, event_kind, last_of_tick);
          failed = 1'b1;
        end else begin
          want = expected_events.pop_front();
          if (button_index !== want.index || event_kind !== want.kind ||
              last_of_tick !== want.last) begin
            $write("%0t: beat mismatch, expected button %0d event %0d last %0b",
                   $time, want.index, want.kind, want.last);
            $display(", got button %0d event %0d last %0b",
                     button_index, event_kind, last_of_tick);
            failed = 1'b1;
          end
        end
        if ($urandom_range(0, 29) == 0) recv_idling = !recv_idling;
        recv_stall = recv_idling ? $urandom_range(0, 17) : 0;
      end
      if (holds_served < holds_asked) begin
        holds_served++;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      lane_state[i] = ST_IDLE;
      lane_timer[i] = '0;
      lane_since_edge[i] = '1;
      lane_prev_level[i] = 1'b1;
      hold_left[i] = $urandom_range(0, 6);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (RESET_CFG_TICKS[k]) pending_ticks.push_back(RESET_CFG_TICKS[k]);
    drain_all();
    program_config(8'hFF, 8'hF0, 16'd0, 16'd0, 16'd0, 16'd1);
    foreach (FAST_CFG_TICKS[k]) pending_ticks.push_back(FAST_CFG_TICKS[k]);
    drain_all();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_config(8'hFF, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd1);
        1: program_config(8'hA5, 8'h00, '1, '1, '1, '1);
        3: program_config(8'hFF, 8'hFF, 16'd1, 16'd1, 16'd3, 16'd2);
        default: program_config(button_mask_t'($urandom_range(0, 255)),
                                button_mask_t'($urandom_range(0, 255)),
                                pick_ticks(0, 6), pick_ticks(0, 4),
                                pick_ticks(0, 8), pick_ticks(1, 5));
      endcase
      if (p == 3) holds_asked++;
      for (int n = 0; n < ((p == 1) ? 12 : 54); n++) begin
        pending_ticks.push_back(next_levels());
      end
      drain_all();
    end

    if (!failed) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
